>>> rtl/utf8mt_pkg.sv
// Shared types and constants for the UTF-8 / modified UTF-8 transcoder.
`default_nettype none

package utf8mt_pkg;

   localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap naturally
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CP_W = 21;

   localparam logic [7:0]      BYTE_SURR_LEAD = 8'hed;
   localparam logic [7:0]      BYTE_NUL_LEAD  = 8'hc0;
   localparam logic [7:0]      BYTE_CONT      = 8'h80;
   localparam logic [CP_W-1:0] CP_MAX_1B      = 21'h00007f;
   localparam logic [CP_W-1:0] CP_MAX_2B      = 21'h0007ff;
   localparam logic [CP_W-1:0] CP_MAX_3B      = 21'h00ffff;
   localparam logic [CP_W-1:0] CP_MAX_UNI     = 21'h10ffff;
   localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;

   typedef enum logic [1:0] {
      CMD_ENC_MOD,
      CMD_ENC_STD,
      CMD_ERROR
   } cmd_kind_type;

   // One decoded character (or error) handed from front to back.
   typedef struct packed {
      cmd_kind_type    kind;
      logic [CP_W-1:0] cp;
      logic            last;
      logic            done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/utf8mt_front.sv
// Front end: gathers source bytes into sequences and decodes code points.
`default_nettype none

module utf8mt_front
   import utf8mt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_end_of_string,
   input  wire queue_status_type q_status,
   output logic                  push_valid,
   output cmd_type               push_entry
);

   logic            dir_ff, dir_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [2:0]      exp_ff, exp_in;
   logic            skip_ff, skip_in;
   logic [5:0][7:0] pend_ff, pend_in;
   logic            hold_valid_ff, hold_valid_in;
   cmd_type         hold_ff, hold_in;

   logic            acc;
   logic [5:0][7:0] merged;
   logic [2:0]      lead;
   logic [2:0]      cnt_next;
   logic            pair_und;
   logic            start;
   logic            case_b;
   logic            bad;
   logic            first_v;
   logic            main_v;
   logic [CP_W-1:0] main_cp;
   cmd_type         first_cmd;
   cmd_type         main_cmd;

   // Sequence length for a lead byte, 0 when the byte cannot open one.
   function automatic logic [2:0] lead_len(input logic [7:0] b, input logic dir);
      logic [2:0] len;
      len = 3'd0;
      if (!dir) begin
         if (b <= 8'h7f)               len = 3'd1;
         else if (b[7:5] == 3'b110)    len = 3'd2;
         else if (b[7:4] == 4'b1110)   len = 3'd3;
         else if (b[7:3] == 5'b11110)  len = 3'd4;
      end else begin
         if (b inside {[8'h01:8'h7f]}) len = 3'd1;
         else if (b[7:5] == 3'b110)    len = 3'd2;
         else if (b == BYTE_SURR_LEAD) len = 3'd6;
         else if (b[7:4] == 4'b1110)   len = 3'd3;
      end
      return len;
   endfunction

   function automatic logic [CP_W-1:0] seq_cp(input logic [5:0][7:0] p,
                                              input logic [2:0] len);
      logic [CP_W-1:0] cp;
      cp = '0;
      case (len)
         3'd2: cp = {10'd0, p[0][4:0], p[1][5:0]};
         3'd3: cp = {5'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
         3'd4: cp = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
         default: cp = (CP_SUPP_BASE + {1'b0, p[1][3:0], 16'd0})
                       | {5'd0, p[2][5:0], p[4][3:0], p[5][5:0]};
      endcase
      return cp;
   endfunction

   assign req_stall = hold_valid_ff || q_status.full;
   assign acc       = req_valid && !req_stall;
   assign lead      = lead_len(req_in_byte, dir_ff);
   assign cnt_next  = 3'(cnt_ff + 3'd1);
   assign pair_und  = dir_ff && (exp_ff == 3'd6) && (cnt_ff == 3'd3);
   assign start     = (cnt_ff == 3'd0) || (exp_ff == 3'd0);
   assign case_b    = !start && pair_und && (req_in_byte != BYTE_SURR_LEAD);

   // Stored bytes with the incoming byte dropped in at the fill position.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         merged[i] = (cnt_ff == 3'(i)) ? req_in_byte : pend_ff[i];
      end
   end

   always_comb begin
      dir_in        = dir_ff;
      cnt_in        = cnt_ff;
      exp_in        = exp_ff;
      skip_in       = skip_ff;
      pend_in       = pend_ff;
      hold_valid_in = hold_valid_ff && q_status.full;
      hold_in       = hold_ff;
      bad           = 1'b0;
      first_v       = 1'b0;
      main_v        = 1'b0;
      main_cp       = '0;
      push_valid    = 1'b0;
      push_entry    = hold_ff;

      if (csr_write_enable) begin
         dir_in  = csr_write_data;
         cnt_in  = 3'd0;
         exp_in  = 3'd0;
         skip_in = 1'b0;
      end else if (acc) begin
         if (skip_ff) begin
            if (req_end_of_string) skip_in = 1'b0;
         end else begin
            if (start || case_b) begin
               // a broken-off ED xx xx goes out first, then this byte leads
               first_v    = case_b;
               pend_in[0] = req_in_byte;
               if (lead == 3'd0) begin
                  bad    = 1'b1;
                  cnt_in = 3'd0;
                  exp_in = 3'd0;
               end else if (lead == 3'd1) begin
                  main_v  = 1'b1;
                  main_cp = {13'd0, req_in_byte};
                  cnt_in  = 3'd0;
                  exp_in  = 3'd0;
               end else begin
                  cnt_in = 3'd1;
                  exp_in = lead;
                  if (req_end_of_string) bad = 1'b1;
               end
            end else begin
               if (cnt_ff < 3'd6) begin
                  pend_in[cnt_ff] = req_in_byte;
               end
               cnt_in = cnt_next;
               if (cnt_next == exp_ff) begin
                  main_v  = 1'b1;
                  main_cp = seq_cp(merged, exp_ff);
                  cnt_in  = 3'd0;
                  exp_in  = 3'd0;
               end else if (req_end_of_string) begin
                  if (dir_ff && (exp_ff == 3'd6) && (cnt_next == 3'd3)) begin
                     main_v  = 1'b1;
                     main_cp = seq_cp(merged, 3'd3);
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
            if (bad) begin
               main_v = 1'b1;
               if (!req_end_of_string) skip_in = 1'b1;
            end
         end
         if (req_end_of_string) begin
            cnt_in  = 3'd0;
            exp_in  = 3'd0;
            skip_in = 1'b0;
         end
      end

      first_cmd.kind = CMD_ENC_STD;
      first_cmd.cp   = seq_cp(merged, 3'd3);
      first_cmd.last = !main_v;
      first_cmd.done = req_end_of_string && !main_v;

      main_cmd.kind  = bad ? CMD_ERROR : (dir_ff ? CMD_ENC_STD : CMD_ENC_MOD);
      main_cmd.cp    = main_cp;
      main_cmd.last  = 1'b1;
      main_cmd.done  = req_end_of_string;

      if (hold_valid_ff) begin
         push_valid = !q_status.full;
         push_entry = hold_ff;
      end else if (first_v || main_v) begin
         push_valid = 1'b1;
         push_entry = first_v ? first_cmd : main_cmd;
         if (first_v && main_v) begin
            hold_valid_in = 1'b1;
            hold_in       = main_cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= 1'b0;
         cnt_ff        <= 3'd0;
         exp_ff        <= 3'd0;
         skip_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         dir_ff        <= dir_in;
         cnt_ff        <= cnt_in;
         exp_ff        <= exp_in;
         skip_ff       <= skip_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

>>> rtl/utf8mt_queue.sv
// Short command queue between the decode front end and the encode back end.
`default_nettype none

module utf8mt_queue
   import utf8mt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire cmd_type  push_entry,
   input  wire logic     pop,
   output cmd_type       pop_entry,
   output queue_status_type status
);

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop)      count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      else if (!push_valid && pop) count_in = QUEUE_CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/utf8mt_back.sv
// Back end: encodes a code point in the target form and sends it one beat per byte.
`default_nettype none

module utf8mt_back
   import utf8mt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire cmd_type          pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_seq_error,
   output logic                  rsp_string_done
);

   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      n;
      logic            err;
   } enc_type;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      byte_ff, byte_in;
   logic            run_last_ff, run_last_in;
   logic            err_ff, err_in;
   logic            done_ff, done_in;
   logic [2:0]      rem_ff, rem_in;
   logic [4:0][7:0] shift_ff, shift_in;
   logic            cmd_last_ff, cmd_last_in;
   logic            cmd_done_ff, cmd_done_in;

   logic            out_free;
   logic [2:0]      rem_next;
   enc_type         enc;

   function automatic enc_type encode(input cmd_type c);
      enc_type         e;
      logic [CP_W-1:0] cp;
      logic [3:0]      plane;
      cp      = c.cp;
      plane   = 4'(cp[20:16] - 5'd1);
      e.bytes = '0;
      e.n     = 3'd1;
      e.err   = 1'b0;
      case (c.kind)
         CMD_ENC_MOD, CMD_ENC_STD: begin
            if ((c.kind == CMD_ENC_MOD) && (cp == '0)) begin
               e.bytes[0] = BYTE_NUL_LEAD;
               e.bytes[1] = BYTE_CONT;
               e.n        = 3'd2;
            end else if (cp <= CP_MAX_1B) begin
               e.bytes[0] = cp[7:0];
            end else if (cp <= CP_MAX_2B) begin
               e.bytes[0] = {3'b110, cp[10:6]};
               e.bytes[1] = {2'b10, cp[5:0]};
               e.n        = 3'd2;
            end else if (cp <= CP_MAX_3B) begin
               e.bytes[0] = {4'b1110, cp[15:12]};
               e.bytes[1] = {2'b10, cp[11:6]};
               e.bytes[2] = {2'b10, cp[5:0]};
               e.n        = 3'd3;
            end else if (c.kind == CMD_ENC_STD) begin
               e.bytes[0] = {5'b11110, cp[20:18]};
               e.bytes[1] = {2'b10, cp[17:12]};
               e.bytes[2] = {2'b10, cp[11:6]};
               e.bytes[3] = {2'b10, cp[5:0]};
               e.n        = 3'd4;
            end else if (cp <= CP_MAX_UNI) begin
               // surrogate pair, high half then low half
               e.bytes[0] = BYTE_SURR_LEAD;
               e.bytes[1] = {4'b1010, plane};
               e.bytes[2] = {2'b10, cp[15:10]};
               e.bytes[3] = BYTE_SURR_LEAD;
               e.bytes[4] = {4'b1011, cp[9:6]};
               e.bytes[5] = {2'b10, cp[5:0]};
               e.n        = 3'd6;
            end else begin
               e.err = 1'b1;
            end
         end
         CMD_ERROR: e.err = 1'b1;
         default:   e.err = 1'b1;
      endcase
      return e;
   endfunction

   assign enc      = encode(pop_entry);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = out_free && (rem_ff == 3'd0) && !q_status.empty;
   assign rem_next = 3'(rem_ff - 3'd1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      run_last_in  = run_last_ff;
      err_in       = err_ff;
      done_in      = done_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      cmd_last_in  = cmd_last_ff;
      cmd_done_in  = cmd_done_ff;
      if (out_free) begin
         if (rem_ff != 3'd0) begin
            rsp_valid_in = 1'b1;
            byte_in      = shift_ff[0];
            err_in       = 1'b0;
            rem_in       = rem_next;
            shift_in     = {8'd0, shift_ff[4:1]};
            run_last_in  = (rem_next == 3'd0) && cmd_last_ff;
            done_in      = (rem_next == 3'd0) && cmd_done_ff;
         end else if (pop) begin
            rsp_valid_in = 1'b1;
            byte_in      = enc.bytes[0];
            err_in       = enc.err;
            rem_in       = 3'(enc.n - 3'd1);
            shift_in     = enc.bytes[5:1];
            cmd_last_in  = pop_entry.last;
            cmd_done_in  = pop_entry.done;
            run_last_in  = (enc.n == 3'd1) && pop_entry.last;
            done_in      = (enc.n == 3'd1) && pop_entry.done;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rem_ff       <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      run_last_ff <= run_last_in;
      err_ff      <= err_in;
      done_ff     <= done_in;
      shift_ff    <= shift_in;
      cmd_last_ff <= cmd_last_in;
      cmd_done_ff <= cmd_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_seq_error   = err_ff;
   assign rsp_string_done = done_ff;

   a_mid_char_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rem_ff != 3'd0)) |-> !run_last_ff)
      else $error("run_last beat while bytes of the character remain");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_ff) |-> (run_last_ff && (rem_ff == 3'd0)))
      else $error("error beat is not the last beat of its input byte");

endmodule

`default_nettype wire

>>> rtl/utf8_modified_utf8_transcoder.sv
// Top level: UTF-8 <-> modified UTF-8 byte-stream transcoder.
// Throughput: one source byte per cycle while the 4-entry command queue has room and no
// second command is held; output one beat per cycle while rsp_stall is low. A character
// encodes to 1 to 6 bytes; a byte that flushes ED xx xx and starts a char holds off input
// until its second command is pushed. Commands pass the queue, then the output register.
// Reset: synchronous active high; clears direction, sequence state, queue and output.
`default_nettype none

module utf8_modified_utf8_transcoder
   import utf8mt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_string,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_seq_error,
   output logic            rsp_string_done
);

   queue_status_type q_status;
   logic             push_valid;
   cmd_type          push_entry;
   logic             pop;
   cmd_type          pop_entry;

   utf8mt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   utf8mt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   utf8mt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_seq_error   (rsp_seq_error),
      .rsp_string_done (rsp_string_done)
   );

endmodule

`default_nettype wire

>>> sim/utf8_modified_utf8_transcoder_checker.sv
// Checker for the UTF-8 / modified UTF-8 transcoder: predicts result beats and compares them.
`timescale 1ns / 1ps

module utf8_modified_utf8_transcoder_checker
   import utf8mt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_string,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_run_last,
   input  wire logic       rsp_seq_error,
   input  wire logic       rsp_string_done,
   output int              mismatch_count,
   output int              beats_owed
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
      logic       done;
   } out_beat_type;

   out_beat_type owed_q[$];
   logic         to_standard;
   logic [7:0]   held [0:5];
   int unsigned  held_cnt;
   int unsigned  seq_len;
   logic         skipping;

   initial begin
      mismatch_count = 0;
      beats_owed     = 0;
   end

   function automatic void owe(input logic [7:0] b, input logic err);
      out_beat_type nb;
      nb      = '0;
      nb.data = err ? 8'h00 : b;
      nb.err  = err;
      owed_q.push_back(nb);
   endfunction

   function automatic logic [7:0] tail6(input logic [5:0] bits);
      return BYTE_CONT | {2'd0, bits};
   endfunction

   // Re-encode one code point in the target encoding.
   function automatic void emit_code(input logic [31:0] cp);
      logic [4:0] plane;
      plane = cp[20:16] - 5'd1;
      if (!to_standard && cp == 0) begin
         owe(BYTE_NUL_LEAD, 1'b0);
         owe(BYTE_CONT, 1'b0);
      end else if (cp <= CP_MAX_1B) begin
         owe(cp[7:0], 1'b0);
      end else if (cp <= CP_MAX_2B) begin
         owe(8'hc0 | {3'd0, cp[10:6]}, 1'b0);
         owe(tail6(cp[5:0]), 1'b0);
      end else if (cp <= CP_MAX_3B) begin
         owe(8'he0 | {4'd0, cp[15:12]}, 1'b0);
         owe(tail6(cp[11:6]), 1'b0);
         owe(tail6(cp[5:0]), 1'b0);
      end else if (to_standard) begin
         owe(8'hf0 | {5'd0, cp[20:18]}, 1'b0);
         owe(tail6(cp[17:12]), 1'b0);
         owe(tail6(cp[11:6]), 1'b0);
         owe(tail6(cp[5:0]), 1'b0);
      end else if (cp <= CP_MAX_UNI) begin
         owe(BYTE_SURR_LEAD, 1'b0);
         owe(8'ha0 | {4'd0, plane[3:0]}, 1'b0);
         owe(tail6(cp[15:10]), 1'b0);
         owe(BYTE_SURR_LEAD, 1'b0);
         owe(8'hb0 | {4'd0, cp[9:6]}, 1'b0);
         owe(tail6(cp[5:0]), 1'b0);
      end else begin
         owe(8'h00, 1'b1);
      end
   endfunction

   function automatic logic [31:0] seq_value(input int unsigned len);
      case (len)
         1: return {24'd0, held[0]};
         2: return {21'd0, held[0][4:0], held[1][5:0]};
         3: return {16'd0, held[0][3:0], held[1][5:0], held[2][5:0]};
         4: return {11'd0, held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
         default: return (32'h10000 + {12'd0, held[1][3:0], 16'd0})
                         | {16'd0, held[2][5:0], 10'd0}
                         | {22'd0, held[4][3:0], 6'd0}
                         | {26'd0, held[5][5:0]};
      endcase
   endfunction

   function automatic bit open_seq(input logic [7:0] b);
      int unsigned len;
      len = 0;
      if (!to_standard) begin
         if (b <= 8'h7f)                len = 1;
         else if (b[7:5] == 3'b110)     len = 2;
         else if (b[7:4] == 4'b1110)    len = 3;
         else if (b[7:3] == 5'b11110)   len = 4;
      end else begin
         if (b != 8'h00 && b <= 8'h7f)  len = 1;
         else if (b[7:5] == 3'b110)     len = 2;
         else if (b == BYTE_SURR_LEAD)  len = 6;
         else if (b[7:4] == 4'b1110)    len = 3;
      end
      if (len == 0) begin
         held_cnt = 0;
         seq_len  = 0;
         return 1'b0;
      end
      held[0]  = b;
      held_cnt = 1;
      seq_len  = len;
      return 1'b1;
   endfunction

   // ED xx xx seen, fourth byte decides between a 3-byte char and a pair
   function automatic bit pair_open();
      return to_standard && seq_len == 6 && held_cnt == 3;
   endfunction

   task automatic predict_beat(input logic [7:0] b, input logic eos);
      bit           bad;
      int           first;
      out_beat_type tail;
      bad   = 1'b0;
      first = owed_q.size();
      if (skipping) begin
         if (eos) skipping = 1'b0;
         return;
      end
      if (held_cnt == 0 || seq_len == 0) begin
         bad = !open_seq(b);
      end else if (pair_open() && b != BYTE_SURR_LEAD) begin
         emit_code(seq_value(3));
         bad = !open_seq(b);
      end else if (held_cnt < 6) begin
         held[held_cnt] = b;
         held_cnt++;
      end
      if (!bad && held_cnt == seq_len) begin
         emit_code(seq_value(seq_len));
         held_cnt = 0;
         seq_len  = 0;
      end else if (!bad && eos) begin
         if (pair_open()) emit_code(seq_value(3));
         else bad = 1'b1;
      end
      if (bad) begin
         owe(8'h00, 1'b1);
         if (!eos) skipping = 1'b1;
      end
      if (eos) begin
         held_cnt = 0;
         seq_len  = 0;
         skipping = 1'b0;
      end
      if (owed_q.size() > first) begin
         tail      = owed_q.pop_back();
         tail.last = 1'b1;
         tail.done = eos;
         owed_q.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      out_beat_type want;
      if (reset) begin
         to_standard = 1'b0;
         held_cnt    = 0;
         seq_len     = 0;
         skipping    = 1'b0;
         owed_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $error("unexpected beat: out_byte %h seq_error %b", rsp_out_byte, rsp_seq_error);
               mismatch_count++;
            end else begin
               want = owed_q.pop_front();
               // data byte carries no meaning on an error beat
               if (!want.err && rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %h, actual %h", want.data, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_run_last !== want.last) begin
                  $error("run_last: expected %b, actual %b", want.last, rsp_run_last);
                  mismatch_count++;
               end
               if (rsp_seq_error !== want.err) begin
                  $error("seq_error: expected %b, actual %b", want.err, rsp_seq_error);
                  mismatch_count++;
               end
               if (rsp_string_done !== want.done) begin
                  $error("string_done: expected %b, actual %b", want.done, rsp_string_done);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            to_standard = csr_write_data;
            held_cnt    = 0;
            seq_len     = 0;
            skipping    = 1'b0;
         end
         if (req_valid && !req_stall) predict_beat(req_in_byte, req_end_of_string);
      end
      beats_owed <= owed_q.size();
   end

endmodule

>>> sim/utf8_modified_utf8_transcoder_tb.sv
// Testbench top for the UTF-8 / modified UTF-8 transcoder: clock, stimulus and verdict.
`timescale 1ns / 1ps

module utf8_modified_utf8_transcoder_tb;

   localparam logic TO_MODIFIED   = 1'b0;
   localparam logic TO_STANDARD   = 1'b1;
   localparam int   CYCLE_LIMIT   = 200000;
   localparam int   SETTLE_CYCLES = 24;
   localparam int   LONG_HOLD     = 160;

   typedef logic [7:0] byte_q_type[$];

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       csr_write_enable  = 1'b0;
   logic       csr_write_data    = 1'b0;
   logic       req_valid         = 1'b0;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_stall         = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   wire  [7:0] rsp_out_byte;
   wire        rsp_run_last;
   wire        rsp_seq_error;
   wire        rsp_string_done;

   int   mismatch_count;
   int   beats_owed;
   int   cycle_count = 0;
   logic cur_dir     = TO_MODIFIED;
   logic req_gaps    = 1'b1;
   logic rsp_gaps    = 1'b1;
   logic hold_go     = 1'b0;
   bit   hold_taken  = 1'b0;
   int   hold_left   = 0;

   utf8_modified_utf8_transcoder u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_seq_error     (rsp_seq_error),
      .rsp_string_done   (rsp_string_done)
   );

   utf8_modified_utf8_transcoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_seq_error     (rsp_seq_error),
      .rsp_string_done   (rsp_string_done),
      .mismatch_count    (mismatch_count),
      .beats_owed        (beats_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_modified_utf8_transcoder_tb: done, errors");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps && ($urandom_range(0, 99) < 32);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      while (req_gaps && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_str(input byte_q_type s);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   // Stop offering and wait until every owed beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic d);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= d;
      cur_dir          = d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] cont_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) != 0) c[7:6] = 2'b10;
      return c;
   endfunction

   // Strings of mostly well-formed characters in the current source encoding,
   // with stray bytes and chopped tails mixed in.
   task automatic run_random(input int budget);
      byte_q_type s;
      int         sent;
      int         kind;
      logic [7:0] lead;
      sent = 0;
      while (sent < budget) begin
         s.delete();
         repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
               s.push_back(8'($urandom_range(0, 255)));
            end else if (cur_dir == TO_MODIFIED) begin
               case (kind)
                  2, 3: begin
                     lead = {3'b110, 5'($urandom_range(0, 31))};
                     s.push_back(lead);
                     s.push_back(cont_byte());
                  end
                  4, 5: begin
                     lead = {4'b1110, 4'($urandom_range(0, 15))};
                     s.push_back(lead);
                     repeat (2) s.push_back(cont_byte());
                  end
                  6, 7: begin
                     if ($urandom_range(0, 7) == 0)
                        lead = {5'b11110, 3'($urandom_range(0, 7))};
                     else
                        lead = 8'hf0 + 8'($urandom_range(0, 4));
                     s.push_back(lead);
                     repeat (3) s.push_back(cont_byte());
                  end
                  default: s.push_back(8'($urandom_range(0, 127)));
               endcase
            end else begin
               case (kind)
                  2, 3: begin
                     lead = {3'b110, 5'($urandom_range(0, 31))};
                     s.push_back(lead);
                     s.push_back(cont_byte());
                  end
                  4: begin
                     lead = {4'b1110, 4'($urandom_range(0, 15))};
                     s.push_back(lead);
                     repeat (2) s.push_back(cont_byte());
                  end
                  5, 6, 7: begin
                     s.push_back(8'hed);
                     s.push_back({4'ha, 4'($urandom_range(0, 15))});
                     s.push_back(cont_byte());
                     s.push_back(8'hed);
                     s.push_back({4'hb, 4'($urandom_range(0, 15))});
                     s.push_back(cont_byte());
                  end
                  default: s.push_back(8'($urandom_range(1, 127)));
               endcase
            end
         end
         if ($urandom_range(0, 9) == 0 && s.size() > 1) lead = s.pop_back();
         send_str(s);
         sent += s.size();
      end
   endtask

   initial begin : stimulus
      byte_q_type pat;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // UTF-8 in: NUL, one char of each length up to the top code point,
      // a 4-byte value past the top, and a string cut short
      write_direction(TO_MODIFIED);
      pat = '{8'h00};
      send_str(pat);
      pat = '{8'h7f, 8'hc2, 8'ha9, 8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_str(pat);
      pat = '{8'hf4, 8'h90, 8'h80, 8'h80};
      send_str(pat);
      pat = '{8'he2, 8'h82};
      send_str(pat);
      run_random(60);

      // modified UTF-8 in: overlong NUL, surrogate pair, ED xx xx then another
      // lead, ED xx xx at the end, bad lead with the rest skipped
      write_direction(TO_STANDARD);
      pat = '{8'hc0, 8'h80};
      send_str(pat);
      pat = '{8'hed, 8'ha0, 8'h80, 8'hed, 8'hb0, 8'h80};
      send_str(pat);
      pat = '{8'hed, 8'h9f, 8'hbf, 8'h41};
      send_str(pat);
      pat = '{8'hed, 8'ha0, 8'h80};
      send_str(pat);
      pat = '{8'hff, 8'h41};
      send_str(pat);
      hold_go <= 1'b1;
      run_random(60);
      // leave a sequence open; the register write must drop it
      send_byte(8'he2, 1'b0);

      write_direction(TO_MODIFIED);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_random(40);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      run_random(30);

      write_direction(TO_STANDARD);
      run_random(65);

      drain();
      if (mismatch_count == 0 && beats_owed == 0) begin
         $display("utf8_modified_utf8_transcoder_tb: done, clean");
      end else begin
         if (beats_owed != 0) $error("%0d result beats never arrived", beats_owed);
         $display("utf8_modified_utf8_transcoder_tb: done, errors");
      end
      $finish;
   end

endmodule
